### design/pid_controller_step_top_assert.svh
// assertion macros for the pid controller step block
`ifndef PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`define PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`ifndef SYNTH
`define PST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid step check failed: same cycle");
`define PST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid step check failed: next cycle");
`else
`define PST_ASSERT_IMP(lbl, ante, cons)
`define PST_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/pid_pkg.sv
// shared types, codes and constants of the pid controller step block
`default_nettype none
package pid_pkg;
  localparam int DATA_W_DEF  = 32;
  localparam int INTEG_W_DEF = 48;
  localparam int FRAC_W      = 16;
  localparam int MAG_W       = 64;
  localparam int DIGIT_W     = 16;
  localparam int NUM_DIGITS  = MAG_W / DIGIT_W;
  localparam int CFG_IDX_W   = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_GAIN_P     = 3'd0;
  localparam cfg_idx_t REG_GAIN_I     = 3'd1;
  localparam cfg_idx_t REG_GAIN_D     = 3'd2;
  localparam cfg_idx_t REG_TARGET     = 3'd3;
  localparam cfg_idx_t REG_LIMIT_LOW  = 3'd4;
  localparam cfg_idx_t REG_LIMIT_HIGH = 3'd5;

  typedef logic [1:0] mul_op_t;
  localparam mul_op_t OP_INC = 2'd0;
  localparam mul_op_t OP_P   = 2'd1;
  localparam mul_op_t OP_I   = 2'd2;
  localparam mul_op_t OP_D   = 2'd3;

  typedef logic [1:0] hit_t;
  localparam hit_t HIT_NONE = 2'd0;
  localparam hit_t HIT_HIGH = 2'd1;
  localparam hit_t HIT_LOW  = 2'd2;

  typedef struct packed {
    logic    load;
    logic    calc_err;
    logic    mul_start;
    logic    mul_take;
    mul_op_t mul_op;
    logic    div_start;
    logic    div_take;
    logic    out_load;
  } pid_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic zero_step;
  } pid_stat_t;
endpackage
`default_nettype wire

### design/pid_mul.sv
// shared sign-magnitude multiplier, one 16-bit digit of b per cycle
`default_nettype none
module pid_mul import pid_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [DATA_WIDTH-1:0]       a,
  input  wire logic signed [MAG_W-1:0]            b,
  output logic                                    done,
  output logic signed [DATA_WIDTH+MAG_W-1:0]      prod
);
  localparam int PW = DATA_WIDTH + MAG_W;
  localparam int CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic                    busy_r, fix_r, done_r, neg_r;
  logic [CW-1:0]           cnt_r;
  logic [DATA_WIDTH-1:0]   amag_r;
  logic [MAG_W-1:0]        bmag_r;
  logic [PW-1:0]           acc_r;
  logic [DATA_WIDTH+DIGIT_W-1:0] pp;

  // partial product of |a| and the top digit still pending
  assign pp = amag_r * bmag_r[MAG_W-1 -: DIGIT_W];

  // control of the digit loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_DIGITS - 1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operand magnitudes and accumulator, most significant digit first
  always_ff @(posedge clk) begin
    if (start) begin
      amag_r <= a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
      bmag_r <= b[MAG_W-1] ? MAG_W'(-b) : MAG_W'(b);
      neg_r  <= a[DATA_WIDTH-1] ^ b[MAG_W-1];
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r  <= (acc_r << DIGIT_W) + PW'(pp);
      bmag_r <= bmag_r << DIGIT_W;
    end else if (fix_r) begin
      acc_r <= neg_r ? PW'(-acc_r) : acc_r;
    end
  end

  assign done = done_r;
  assign prod = $signed(acc_r);
endmodule
`default_nettype wire

### design/pid_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module pid_div import pid_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [DATA_WIDTH+FRAC_W:0]        num,
  input  wire logic [DATA_WIDTH-1:0]             den,
  output logic                                   done,
  output logic [DATA_WIDTH+FRAC_W:0]             quo
);
  localparam int NW  = DATA_WIDTH + FRAC_W + 1;
  localparam int CNW = $clog2(NW);

  logic                  busy_r, done_r;
  logic [CNW-1:0]        cnt_r;
  logic [NW-1:0]         num_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH:0]   rem_sh, rem_sub;
  logic                  qbit;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    rem_sub = rem_sh - {1'b0, den};
    qbit    = (rem_sh >= {1'b0, den});
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], qbit};
      rem_r <= qbit ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;
endmodule
`default_nettype wire

### design/pid_dp.sv
// datapath: registers, error, integral, derivative, term sum and clamp
`default_nettype none
module pid_dp import pid_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_W_DEF,
  parameter int INTEGRAL_WIDTH = INTEG_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pid_cmd_t                     cmd,
  output pid_stat_t                         stat,
  input  wire logic                         cfg_wr_en,
  input  wire cfg_idx_t                     cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data,
  input  wire logic signed [DATA_WIDTH-1:0] in_measurement,
  input  wire logic [DATA_WIDTH-1:0]        in_step_time,
  output logic signed [DATA_WIDTH-1:0]      out_drive,
  output hit_t                              out_limit_hit,
  output logic                              out_zero_step
);
  localparam int DW = DATA_WIDTH;
  localparam int IW = INTEGRAL_WIDTH;
  localparam int PW = DW + MAG_W;
  localparam int NW = DW + FRAC_W + 1;
  localparam int SW = MAG_W + 2;
  localparam int QX = (NW > MAG_W) ? NW : MAG_W;

  logic signed [DW-1:0] gain_p_r, gain_i_r, gain_d_r, target_r, lim_lo_r, lim_hi_r;
  logic signed [DW-1:0] meas_r, err_r, last_err_r, drive_r;
  logic [DW-1:0]        dt_r;
  logic signed [IW-1:0] integ_r;
  logic signed [SW-1:0] sum_r;
  logic signed [MAG_W-1:0] deriv_r;
  logic                 zero_r, zflag_r;
  hit_t                 hit_r;

  logic signed [DW:0]      err_wide;
  logic signed [DW-1:0]    err_sat;
  logic signed [DW-1:0]    mul_a;
  logic signed [MAG_W-1:0] mul_b;
  logic                    mul_done;
  logic signed [PW-1:0]    prod, prod_sh;
  logic signed [IW-1:0]    inc_sat, integ_sat;
  logic signed [IW:0]      integ_wide;
  logic signed [MAG_W-1:0] term_sat;
  logic signed [DW:0]      diff;
  logic [DW:0]             diff_mag;
  logic                    div_done;
  logic [NW-1:0]           quo;
  logic [QX-1:0]           quo_x;
  logic [MAG_W-2:0]        dmag;
  logic signed [MAG_W-1:0] deriv_nxt;
  logic signed [SW-1:0]    hi_x, lo_x;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      target_r <= '0;
      lim_lo_r <= {1'b1, {(DW-1){1'b0}}};
      lim_hi_r <= {1'b0, {(DW-1){1'b1}}};
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN_P:     gain_p_r <= $signed(cfg_data);
        REG_GAIN_I:     gain_i_r <= $signed(cfg_data);
        REG_GAIN_D:     gain_d_r <= $signed(cfg_data);
        REG_TARGET:     target_r <= $signed(cfg_data);
        REG_LIMIT_LOW:  lim_lo_r <= $signed(cfg_data);
        REG_LIMIT_HIGH: lim_hi_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // saturated error
  always_comb begin
    err_wide = (DW+1)'(target_r) - (DW+1)'(meas_r);
    if (err_wide[DW] != err_wide[DW-1]) begin
      err_sat = {err_wide[DW], {(DW-1){~err_wide[DW]}}};
    end else begin
      err_sat = err_wide[DW-1:0];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_op)
      OP_INC: begin
        mul_a = err_r;
        mul_b = $signed(MAG_W'(dt_r));
      end
      OP_P: begin
        mul_a = gain_p_r;
        mul_b = MAG_W'(err_r);
      end
      OP_I: begin
        mul_a = gain_i_r;
        mul_b = MAG_W'(integ_r);
      end
      default: begin
        mul_a = gain_d_r;
        mul_b = deriv_r;
      end
    endcase
  end

  pid_mul #(.DATA_WIDTH(DW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // product floor-shifted and saturated to integral and term widths
  always_comb begin
    prod_sh = prod >>> FRAC_W;
    if (prod_sh[PW-1:IW-1] != {(PW-IW+1){prod_sh[PW-1]}}) begin
      inc_sat = {prod_sh[PW-1], {(IW-1){~prod_sh[PW-1]}}};
    end else begin
      inc_sat = prod_sh[IW-1:0];
    end
    if (prod_sh[PW-1:MAG_W-1] != {(PW-MAG_W+1){prod_sh[PW-1]}}) begin
      term_sat = {prod_sh[PW-1], {(MAG_W-1){~prod_sh[PW-1]}}};
    end else begin
      term_sat = prod_sh[MAG_W-1:0];
    end
    integ_wide = (IW+1)'(integ_r) + (IW+1)'(inc_sat);
    if (integ_wide[IW] != integ_wide[IW-1]) begin
      integ_sat = {integ_wide[IW], {(IW-1){~integ_wide[IW]}}};
    end else begin
      integ_sat = integ_wide[IW-1:0];
    end
  end

  // error change and its magnitude, scaled for the divider
  always_comb begin
    diff     = (DW+1)'(err_r) - (DW+1)'(last_err_r);
    diff_mag = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
  end

  pid_div #(.DATA_WIDTH(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ({diff_mag, {FRAC_W{1'b0}}}),
    .den   (dt_r),
    .done  (div_done),
    .quo   (quo)
  );

  // derivative magnitude saturated below 2^63, then signed
  always_comb begin
    quo_x = QX'(quo);
    if (|quo_x[QX-1:MAG_W-1]) begin
      dmag = {(MAG_W-1){1'b1}};
    end else begin
      dmag = quo_x[MAG_W-2:0];
    end
    deriv_nxt = diff[DW] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
  end

  assign hi_x = SW'(lim_hi_r);
  assign lo_x = SW'(lim_lo_r);

  // loop state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else begin
      if (cmd.mul_take && cmd.mul_op == OP_INC) begin
        integ_r <= integ_sat;
      end
      if (cmd.out_load) begin
        last_err_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_r <= in_measurement;
      dt_r   <= in_step_time;
    end
    if (cmd.calc_err) begin
      err_r  <= err_sat;
      zero_r <= (dt_r == '0);
    end
    if (cmd.div_take) begin
      deriv_r <= deriv_nxt;
    end
    // term sum: p starts it, i and d add in
    if (cmd.mul_take) begin
      if (cmd.mul_op == OP_P) begin
        sum_r <= SW'(term_sat);
      end else if (cmd.mul_op != OP_INC) begin
        sum_r <= sum_r + SW'(term_sat);
      end
    end
    // clamp, high limit first
    if (cmd.out_load) begin
      zflag_r <= zero_r;
      if (sum_r > hi_x) begin
        drive_r <= lim_hi_r;
        hit_r   <= HIT_HIGH;
      end else if (sum_r < lo_x) begin
        drive_r <= lim_lo_r;
        hit_r   <= HIT_LOW;
      end else begin
        drive_r <= sum_r[DW-1:0];
        hit_r   <= HIT_NONE;
      end
    end
  end

  assign stat.mul_done  = mul_done;
  assign stat.div_done  = div_done;
  assign stat.zero_step = zero_r;

  assign out_drive     = drive_r;
  assign out_limit_hit = hit_r;
  assign out_zero_step = zflag_r;
endmodule
`default_nettype wire

### design/pid_ctrl.sv
// controller: sequences error, integral, terms, derivative and output beat
`default_nettype none
module pid_ctrl import pid_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire pid_stat_t stat,
  output pid_cmd_t       cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_MWAIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DWAIT = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  mul_op_t    op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cmd        = '0;
    cmd.mul_op = op_r;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        op_nxt       = OP_INC;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          cmd.mul_take = 1'b1;
          unique case (op_r)
            OP_INC: begin
              op_nxt    = OP_P;
              state_nxt = S_MUL;
            end
            OP_P: begin
              op_nxt    = OP_I;
              state_nxt = S_MUL;
            end
            OP_I: begin
              state_nxt = stat.zero_step ? S_OUT : S_DIV;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          op_nxt       = OP_D;
          state_nxt    = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output beat holding
  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_INC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

### design/pid_controller_step_top.sv
// PID controller step with output clamp, Q16.16 fixed point.
//
// Input channel: in_valid/in_ready carry one beat of in_measurement (signed)
// and in_step_time (unsigned). Result channel: out_valid/out_ready carry one
// beat of out_drive, out_limit_hit (0 none, 1 high, 2 low) and out_zero_step.
// Configuration: cfg_wr_en with cfg_index 0..5 (gain_p, gain_i, gain_d,
// target, limit_low, limit_high) writes cfg_data; other indexes are ignored.
// Write registers only while the block is idle.
// One beat at a time: the integral increment and the P, I and D products take
// four passes through the shared 32x16 digit multiplier at DATA_WIDTH 32, and
// the bit-serial derivative divider runs before the D pass. With a zero step
// time the divide and derivative multiply are skipped.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register; a new beat is accepted while it
// waits, and a stalled receiver holds the next result in its last step.
// Reset (synchronous, active low) clears integral, last error, limits to
// full range, gains and target to zero, and empties the output register.
`default_nettype none
module pid_controller_step_top import pid_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_W_DEF,
  parameter int INTEGRAL_WIDTH = INTEG_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_measurement,
  input  wire logic [DATA_WIDTH-1:0]        in_step_time,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_drive,
  output logic [1:0]                        out_limit_hit,
  output logic                              out_zero_step,
  input  wire logic                         cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data
);
`include "pid_controller_step_top_assert.svh"

  pid_cmd_t  cmd;
  pid_stat_t stat;

  pid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pid_dp #(
    .DATA_WIDTH     (DATA_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_measurement (in_measurement),
    .in_step_time   (in_step_time),
    .out_drive      (out_drive),
    .out_limit_hit  (out_limit_hit),
    .out_zero_step  (out_zero_step)
  );

  // checks on the sequencing
  `PST_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `PST_ASSERT_IMP(a_take_only_when_done, cmd.mul_take, stat.mul_done)
  `PST_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !out_valid || out_ready)
  `PST_ASSERT_IMP(a_hit_code_valid, out_valid, (out_limit_hit == HIT_NONE) || (out_limit_hit == HIT_HIGH) || (out_limit_hit == HIT_LOW))
endmodule
`default_nettype wire

### tb/sv/pid_controller_step_top_tb.sv
// testbench for the pid controller step block: directed and random beats against a predictor
`timescale 1ns / 100ps
module pid_controller_step_top_tb;
  import pid_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] drive;
    hit_t               hit;
    logic               zero;
  } pid_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_measurement = '0;
  logic [31:0]        in_step_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_drive;
  logic [1:0]         out_limit_hit;
  logic               out_zero_step;
  logic               cfg_wr_en = 1'b0;
  cfg_idx_t           cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // predictor state and register copy
  logic signed [31:0] gain_p, gain_i, gain_d, setpoint, lim_low, lim_high;
  logic signed [47:0] integ_acc;
  logic signed [31:0] prev_err;

  pid_result_t drive_q[$];
  int          mismatches = 0;
  bit          no_gaps = 1'b0;

  pid_controller_step_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_measurement(in_measurement), .in_step_time(in_step_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_drive(out_drive), .out_limit_hit(out_limit_hit), .out_zero_step(out_zero_step),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic wide_t sat_to(wide_t v, int bits);
    wide_t mx, mn;
    mx = (128'sd1 <<< (bits - 1)) - 128'sd1;
    mn = -mx - 128'sd1;
    if (v > mx) return mx;
    if (v < mn) return mn;
    return v;
  endfunction

  // one control step: error, integral, derivative, sum and clamp
  function automatic pid_result_t pid_step(logic signed [31:0] meas, logic [31:0] dt);
    pid_result_t r;
    wide_t e, dtw, inc, diff, mag, qm, deriv, p, i, d, sum, lo, hi;
    dtw = {96'd0, dt};
    e = sat_to(wide_t'(setpoint) - wide_t'(meas), 32);
    inc = sat_to((e * dtw) >>> 16, 48);
    integ_acc = sat_to(wide_t'(integ_acc) + inc, 48);
    r.zero = (dt == 0);
    deriv = 0;
    if (dt != 0) begin
      diff = e - wide_t'(prev_err);
      mag = (diff < 0) ? -diff : diff;
      qm = (mag <<< 16) / dtw;
      deriv = (diff < 0) ? -qm : qm;
    end
    p = sat_to((wide_t'(gain_p) * e) >>> 16, 64);
    i = sat_to((wide_t'(gain_i) * wide_t'(integ_acc)) >>> 16, 64);
    d = sat_to((wide_t'(gain_d) * deriv) >>> 16, 64);
    sum = sat_to(p + i + d, 64);
    lo = lim_low;
    hi = lim_high;
    if (sum > hi) begin
      r.drive = lim_high;
      r.hit = HIT_HIGH;
    end else if (sum < lo) begin
      r.drive = lim_low;
      r.hit = HIT_LOW;
    end else begin
      r.drive = sum[31:0];
      r.hit = HIT_NONE;
    end
    prev_err = e[31:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // register write, enable left high for back-to-back writes
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:     gain_p = val;
      REG_GAIN_I:     gain_i = val;
      REG_GAIN_D:     gain_d = val;
      REG_TARGET:     setpoint = val;
      REG_LIMIT_LOW:  lim_low = val;
      REG_LIMIT_HIGH: lim_high = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] kp, ki, kd, sp, lo, hi);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_TARGET, sp);
    write_reg(REG_LIMIT_LOW, lo);
    write_reg(REG_LIMIT_HIGH, hi);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected result, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // send one input beat and predict its result on acceptance
  task automatic send_beat(logic signed [31:0] meas, logic [31:0] dt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_measurement <= meas;
    in_step_time   <= dt;
    do @(posedge clk); while (!in_ready);
    drive_q.push_back(pid_step(meas, dt));
  endtask

  // mixed-scale random value: full range, small, extreme, or near one
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'h10000 + $urandom_range(0, 32'h1FFFF) - 32'h10000;
    endcase
  endfunction

  function automatic logic [31:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd1;
      default: return $urandom_range(1, 32'h20000);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_beat(32'sh00010000, 32'h00010000);
    send_beat(32'sh80000000, 32'd0);
    send_beat(32'sh7FFFFFFF, 32'hFFFFFFFF);
    drain();
  endtask

  task automatic test_directed();
    // unity gains, full range limits
    set_regs(32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h80000000, 32'h7FFFFFFF);
    send_beat(32'sh00020000, 32'h00010000);
    send_beat(32'sh80000000, 32'h00000001);
    send_beat(32'sh7FFFFFFF, 32'hFFFFFFFF);
    send_beat(32'sh00000000, 32'd0);
    send_beat(32'shFFFF0000, 32'h00008000);
    drain();
    // error saturation, extreme gains
    set_regs(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'hFFF00000, 32'h00100000);
    send_beat(32'sh80000000, 32'hFFFFFFFF);
    send_beat(32'sh80000000, 32'h00000001);
    send_beat(32'sh7FFFFFFF, 32'd0);
    send_beat(32'sh00000000, 32'h00010000);
    drain();
    // crossed limits, negative setpoint; out-of-range indexes are ignored
    set_regs(32'h80000000, 32'h00008000, 32'h80000000, 32'h80000000,
             32'h00050000, 32'hFFFB0000);
    write_reg(cfg_idx_t'(6), 32'h12345678);
    write_reg(cfg_idx_t'(7), 32'hFFFFFFFF);
    cfg_wr_en <= 1'b0;
    send_beat(32'sh7FFFFFFF, 32'h00010000);
    send_beat(32'sh00000000, 32'h00000000);
    send_beat(32'sh00000001, 32'h00000002);
    send_beat(32'shFFFFFFFF, 32'h80000000);
    drain();
    // small gains so the sum lands inside the limits
    set_regs(32'h00000100, 32'h00000010, 32'h00000001, 32'h00030000,
             32'hFFFF0000, 32'h00010000);
    send_beat(32'sh00028000, 32'h00001000);
    send_beat(32'sh00038000, 32'h00001000);
    send_beat(32'sh00030000, 32'd0);
    send_beat(32'sh00000000, 32'h00010000);
    drain();
  endtask

  task automatic test_random();
    logic [31:0] lo, hi;
    for (int ph = 0; ph < 5; ph++) begin
      lo = rand_val();
      hi = rand_val();
      if (ph == 0) begin
        lo = 32'h80000000;
        hi = 32'h7FFFFFFF;
      end else if (ph == 4) begin
        lo = 32'h7FFFFFFF;
        hi = 32'h80000000;
      end
      set_regs(rand_val(), rand_val(), rand_val(), rand_val(), lo, hi);
      no_gaps = (ph == 2);
      for (int k = 0; k < 150; k++)
        send_beat($urandom_range(0, 3) == 0 ? rand_val() : rand_val() >>> 4, rand_dt());
      no_gaps = 1'b0;
      drain();
    end
  endtask

  // result side stall, drawn per beat
  always begin : ready_gen
    int n;
    @(posedge clk);
    if (rst_n) begin
      n = no_gaps ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    pid_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        report("unexpected beat", out_drive, 0);
      end else begin
        w = drive_q.pop_front();
        if (out_drive !== w.drive) report("drive", out_drive, w.drive);
        if (out_limit_hit !== w.hit) report("limit_hit", out_limit_hit, w.hit);
        if (out_zero_step !== w.zero) report("zero_step", out_zero_step, w.zero);
      end
    end
  end

  initial begin
    gain_p = 0; gain_i = 0; gain_d = 0; setpoint = 0;
    lim_low = 32'sh80000000; lim_high = 32'sh7FFFFFFF;
    integ_acc = 0; prev_err = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/pid_pkg.sv
design/pid_mul.sv
design/pid_div.sv
design/pid_dp.sv
design/pid_ctrl.sv
design/pid_controller_step_top.sv
tb/sv/pid_controller_step_top_tb.sv
